[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a trigger implies a condition in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

[rtl/sts_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted table search package
// Shared widths, codes and types of the sorted table search block.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int POS_W       = 11;
  localparam int INDEX_W     = 10;
  localparam int IN_VALUE_W  = 32;
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_INDEX_W = 1;

  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_VALUE_WIDTH = 32;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_ENTRY_COUNT    = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_COMPARE_SIGNED = 1'b1;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } sts_mem_ctrl_t;

endpackage

[rtl/sts_table.sv]
// ----------------------------------------------------------------------------
// Sorted table storage
// Single-port entry memory with registered read data.
// ----------------------------------------------------------------------------
module sts_table #(
  parameter int DEPTH = sts_pkg::DEF_TABLE_DEPTH,
  parameter int WIDTH = sts_pkg::DEF_VALUE_WIDTH
) (
  input  logic                      clk,
  input  sts_pkg::sts_mem_ctrl_t    ctrl,
  input  logic [$clog2(DEPTH)-1:0]  addr,
  input  logic [WIDTH-1:0]          wdata,
  output logic [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[addr] <= wdata;
    end
    if (ctrl.rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

[rtl/sorted_table_binary_search.sv]
// Write request: the entry is written when the request is taken, and the block
// stays ready for the next request. Search request: the range end is clamped to
// entry_count and the first table read is issued; each bisection step is one
// table read and one compare, at most clog2(range length + 1) steps. The result
// is registered at the output once any earlier result there is taken by m_tready.
// Reset clears entry_count, compare_signed, the state and out_valid only.
// ----------------------------------------------------------------------------
// Sorted table binary search
// Stores entries by write request and bisects a range for a key per search.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_table_binary_search #(
  parameter int TABLE_DEPTH = sts_pkg::DEF_TABLE_DEPTH,
  parameter int VALUE_WIDTH = sts_pkg::DEF_VALUE_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // entry_index[9:0], item_value[41:10], range_start[52:42], range_end[63:53]
  input  logic [63:0]                     s_tdata,
  // req_type[0]
  input  logic [0:0]                      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // position[10:0], zero fill[15:11]
  output logic [15:0]                     m_tdata,
  // found[0]
  output logic [0:0]                      m_tuser,
  input  logic                            cfg_we,
  input  logic [sts_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sts_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int POS_W = sts_pkg::POS_W;
  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int IW    = (AW > POS_W) ? AW : POS_W;
  localparam int KW    = (VALUE_WIDTH > sts_pkg::IN_VALUE_W) ? VALUE_WIDTH
                                                            : sts_pkg::IN_VALUE_W;
  localparam logic [VALUE_WIDTH-1:0] SIGN_BIT = VALUE_WIDTH'(1) << (VALUE_WIDTH - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_START, ST_CMP, ST_DONE} state_t;

  state_t                   state;
  logic [POS_W-1:0]         entry_count;
  logic                     compare_signed;
  logic [POS_W-1:0]         lo;
  logic [POS_W-1:0]         hi;
  logic [POS_W-1:0]         mid;
  logic [VALUE_WIDTH-1:0]   key;
  logic                     hit;
  logic                     out_valid;
  logic                     found;
  logic [POS_W-1:0]         position;

  logic [sts_pkg::INDEX_W-1:0] in_index;
  logic [KW-1:0]               in_value;
  logic [POS_W-1:0]            in_start;
  logic [POS_W-1:0]            in_end;
  logic                        accept;
  logic [VALUE_WIDTH-1:0]      sign_mask;
  logic [VALUE_WIDTH-1:0]      key_in;
  logic [POS_W-1:0]            hi_clamp;
  logic [POS_W:0]              sum_start;
  logic [POS_W-1:0]            mid_start;
  logic [VALUE_WIDTH-1:0]      rdata;
  logic [VALUE_WIDTH-1:0]      entry_key;
  logic                        is_greater;
  logic                        is_less;
  logic [POS_W-1:0]            lo_next;
  logic [POS_W-1:0]            hi_next;
  logic [POS_W:0]              sum_next;
  logic [POS_W-1:0]            mid_next;
  logic                        out_free;
  logic [IW-1:0]               addr_wide;
  sts_pkg::sts_mem_ctrl_t      mem_ctrl;

  assign in_index = s_tdata[9:0];
  assign in_value = KW'(s_tdata[41:10]);
  assign in_start = s_tdata[52:42];
  assign in_end   = s_tdata[63:53];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;

  always_comb begin
    sign_mask  = compare_signed ? SIGN_BIT : '0;
    key_in     = in_value[VALUE_WIDTH-1:0] ^ sign_mask;
    hi_clamp   = (in_end > entry_count) ? entry_count : in_end;
    sum_start  = {1'b0, lo} + {1'b0, hi};
    mid_start  = sum_start[POS_W:1];
    entry_key  = rdata ^ sign_mask;
    is_greater = entry_key > key;
    is_less    = entry_key < key;
    lo_next    = is_less ? (mid + POS_W'(1)) : lo;
    hi_next    = is_greater ? mid : hi;
    sum_next   = {1'b0, lo_next} + {1'b0, hi_next};
    mid_next   = sum_next[POS_W:1];
  end

  always_comb begin
    mem_ctrl  = '0;
    addr_wide = IW'(mid_next);
    unique case (state)
      ST_IDLE: begin
        addr_wide      = IW'(in_index);
        mem_ctrl.wr_en = accept && (s_tuser[0] == sts_pkg::REQ_WRITE) &&
                         (32'(in_index) < TABLE_DEPTH);
      end
      ST_START: begin
        addr_wide      = IW'(mid_start);
        mem_ctrl.rd_en = lo < hi;
      end
      ST_CMP: begin
        mem_ctrl.rd_en = (is_greater || is_less) && (lo_next < hi_next);
      end
      ST_DONE: begin
        mem_ctrl = '0;
      end
      default: begin
        mem_ctrl = '0;
      end
    endcase
  end

  sts_table #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (VALUE_WIDTH)
  ) u_table (
    .clk   (clk),
    .ctrl  (mem_ctrl),
    .addr  (addr_wide[AW-1:0]),
    .wdata (in_value[VALUE_WIDTH-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count    <= '0;
      compare_signed <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sts_pkg::REG_ENTRY_COUNT: begin
          entry_count <= (32'(cfg_data) > TABLE_DEPTH) ? POS_W'(TABLE_DEPTH) : cfg_data;
        end
        sts_pkg::REG_COMPARE_SIGNED: begin
          compare_signed <= cfg_data[0];
        end
        default: begin
          compare_signed <= compare_signed;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && m_tready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && (s_tuser[0] == sts_pkg::REQ_SEARCH)) begin
            key   <= key_in;
            lo    <= in_start;
            hi    <= hi_clamp;
            state <= ST_START;
          end
        end
        ST_START: begin
          mid <= mid_start;
          hit <= 1'b0;
          if (lo < hi) begin
            state <= ST_CMP;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_CMP: begin
          if (!is_greater && !is_less) begin
            hit   <= 1'b1;
            state <= ST_DONE;
          end else begin
            lo  <= lo_next;
            hi  <= hi_next;
            mid <= mid_next;
            if (!(lo_next < hi_next)) begin
              state <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            found     <= hit;
            position  <= hit ? mid : entry_count;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = 16'(position);
  assign m_tuser  = found;

  `ASSERT_IMPLY(a_hi_clamped, state == ST_CMP, hi <= entry_count,
                "search range end above entry count")
  `ASSERT_IMPLY(a_mid_in_range, state == ST_CMP, (lo <= mid) && (mid < hi),
                "probe position outside the live range")
  `ASSERT_IMPLY(a_hit_position, out_valid && found, position < entry_count,
                "hit reported beyond the valid entries")
  `ASSERT_IMPLY(a_miss_position, out_valid && !found, position == entry_count,
                "miss not reported as entry count")

endmodule
